[rtl/affc_pkg.sv]
// ----------------------------------------------------------------------------
// affc_pkg: shared types and constants of the affine texture coordinate block
// Fixed-point formats, register indexes, extend modes and the register bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package affc_pkg;

  // Q.16 fixed point: 65536 is 1.0.
  localparam int FRAC_W   = 16;
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // Pixel index and result widths.
  localparam int PIX_W   = 10;
  localparam int PIX_MAX = 1023;
  localparam int SRC_W   = 17;

  // Register field widths.
  localparam int TRANS_W = 18;
  localparam int SCALE_W = 20;
  localparam int ROT_W   = 18;
  localparam int MODE_W  = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Defaults for the top level parameters.
  localparam int DEF_OUT_WIDTH  = 1024;
  localparam int DEF_OUT_HEIGHT = 1024;
  localparam int DEF_FIFO_DEPTH = 4;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANSLATE_U = 3'd0,
    REG_TRANSLATE_V = 3'd1,
    REG_INV_SCALE_U = 3'd2,
    REG_INV_SCALE_V = 3'd3,
    REG_ROT_COS     = 3'd4,
    REG_ROT_SIN     = 3'd5,
    REG_EXTEND_MODE = 3'd6
  } cfg_idx_t;

  // Extend modes; the unused code behaves as mirror.
  typedef enum logic [MODE_W-1:0] {
    EXT_CLAMP  = 2'd0,
    EXT_MIRROR = 2'd1,
    EXT_TILE   = 2'd2
  } ext_mode_t;

  // Register bundle handed to the transform datapath.
  typedef struct packed {
    logic signed [TRANS_W-1:0] translate_u;
    logic signed [TRANS_W-1:0] translate_v;
    logic        [SCALE_W-1:0] inv_scale_u;
    logic        [SCALE_W-1:0] inv_scale_v;
    logic signed [ROT_W-1:0]   rot_cos;
    logic signed [ROT_W-1:0]   rot_sin;
    logic        [MODE_W-1:0]  extend_mode;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/affc_norm.sv]
// ----------------------------------------------------------------------------
// affc_norm: pixel index to centred unit coordinate
// Computes floor(pix * 65536 / DIV) - 32768 over two stages, using a
// reciprocal multiply followed by a single remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module affc_norm #(
  parameter int DIV = affc_pkg::DEF_OUT_WIDTH,
  parameter int C_W = 17
) (
  input  wire                                clk,
  input  wire                                load_a,
  input  wire                                load_b,
  input  wire        [affc_pkg::PIX_W-1:0]   pix,
  output logic signed [C_W-1:0]              coord
);

  localparam int N_W = affc_pkg::PIX_W + affc_pkg::FRAC_W;
  localparam int K   = (2 ** N_W) / DIV;
  localparam int K_W = $clog2(K + 1);
  localparam int Q_W = $clog2((affc_pkg::PIX_MAX * affc_pkg::ONE_Q16) / DIV + 1);
  localparam int D_W = $clog2(DIV + 1);

  localparam logic [K_W-1:0] K_C = K_W'(K);
  localparam logic [D_W-1:0] D_C = D_W'(DIV);

  logic [affc_pkg::PIX_W-1:0]     pix_a;
  logic [Q_W-1:0]                 est_a;
  logic [affc_pkg::PIX_W+K_W-1:0] prod;
  logic [Q_W+D_W-1:0]             est_back;
  logic [N_W-1:0]                 rem;
  logic [Q_W-1:0]                 quo;

  // The estimate is floor(pix * K / 1024): never above the true quotient
  // and at most one below it.
  assign prod = pix * K_C;

  always_ff @(posedge clk) begin
    if (load_a) begin
      pix_a <= pix;
      est_a <= prod[affc_pkg::PIX_W +: Q_W];
    end
  end

  // Remainder check fixes the estimate, then the coordinate is centred.
  assign est_back = est_a * D_C;
  assign rem      = {pix_a, {affc_pkg::FRAC_W{1'b0}}} - N_W'(est_back);
  assign quo      = (rem >= N_W'(DIV)) ? est_a + Q_W'(1) : est_a;

  always_ff @(posedge clk) begin
    if (load_b) begin
      coord <= C_W'(quo) - C_W'(affc_pkg::HALF_Q16);
    end
  end

endmodule

`default_nettype wire

[rtl/affc_front.sv]
// ----------------------------------------------------------------------------
// affc_front: input side of the coordinate generator
// Accepts pixel items and turns them into centred unit coordinates in a
// two-stage pipeline that stalls only when the queue behind it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module affc_front #(
  parameter int OUT_WIDTH  = affc_pkg::DEF_OUT_WIDTH,
  parameter int OUT_HEIGHT = affc_pkg::DEF_OUT_HEIGHT,
  parameter int C_W        = 17
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire        [affc_pkg::PIX_W-1:0] pix_x,
  input  wire        [affc_pkg::PIX_W-1:0] pix_y,
  output logic                             q_valid,
  input  wire                              q_ready,
  output logic signed [C_W-1:0]            q_u,
  output logic signed [C_W-1:0]            q_v
);

  logic valid_a;
  logic valid_b;
  logic load_a;
  logic load_b;

  // Stage b moves when it is empty or the queue takes its item.
  assign load_b   = valid_a && (!valid_b || q_ready);
  assign in_ready = !valid_a || !valid_b || q_ready;
  assign load_a   = in_valid && in_ready;
  assign q_valid  = valid_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (load_a) begin
        valid_a <= 1'b1;
      end else if (load_b) begin
        valid_a <= 1'b0;
      end
      if (load_b) begin
        valid_b <= 1'b1;
      end else if (q_ready) begin
        valid_b <= 1'b0;
      end
    end
  end

  // One normalizer per axis, each with its own image size.
  affc_norm #(.DIV(OUT_WIDTH), .C_W(C_W)) u_norm_x (
    .clk   (clk),
    .load_a(load_a),
    .load_b(load_b),
    .pix   (pix_x),
    .coord (q_u)
  );

  affc_norm #(.DIV(OUT_HEIGHT), .C_W(C_W)) u_norm_y (
    .clk   (clk),
    .load_a(load_a),
    .load_b(load_b),
    .pix   (pix_y),
    .coord (q_v)
  );

endmodule

`default_nettype wire

[rtl/affc_fifo.sv]
// ----------------------------------------------------------------------------
// affc_fifo: short queue between the front and the transform datapath
// Register-based first-in first-out store with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module affc_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = affc_pkg::DEF_FIFO_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr_valid,
  output logic             wr_ready,
  input  wire  [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  wire              rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/affc_back.sv]
// ----------------------------------------------------------------------------
// affc_back: rotate, scale, translate and wrap
// Five-stage datapath from centred coordinates to wrapped source
// coordinates; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module affc_back #(
  parameter int C_W = 17
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  affc_pkg::cfg_t               cfg,
  input  wire                                q_valid,
  output logic                               q_ready,
  input  wire  signed [C_W-1:0]              q_u,
  input  wire  signed [C_W-1:0]              q_v,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic        [affc_pkg::SRC_W-1:0]  src_u,
  output logic        [affc_pkg::SRC_W-1:0]  src_v
);

  localparam int P_W  = C_W + affc_pkg::ROT_W;
  localparam int R_W  = P_W + 1 - affc_pkg::FRAC_W;
  localparam int SC_W = R_W + affc_pkg::SCALE_W + 1;
  localparam int T_W  = SC_W - affc_pkg::FRAC_W + 1;
  localparam int S_W  = affc_pkg::SRC_W;

  logic adv;
  logic v1, v2, v3, v4;

  logic signed [P_W-1:0]  p_uc, p_vs, p_us, p_vc;
  logic signed [P_W:0]    sum_u, sum_v;
  logic signed [R_W-1:0]  r_u, r_v;
  logic signed [SC_W-1:0] m_u, m_v;
  logic signed [SC_W-1:0] m_u_next, m_v_next;
  logic signed [T_W-1:0]  t_u, t_v;
  logic signed [T_W-1:0]  t_u_next, t_v_next;

  // The whole datapath moves together whenever the output is free.
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Stage 1: rotation products.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_uc <= q_u * cfg.rot_cos;
      p_vs <= q_v * cfg.rot_sin;
      p_us <= q_u * cfg.rot_sin;
      p_vc <= q_v * cfg.rot_cos;
    end
  end

  // Stage 2: rotation sums, floored to Q.16.
  assign sum_u = {p_uc[P_W-1], p_uc} - {p_vs[P_W-1], p_vs};
  assign sum_v = {p_us[P_W-1], p_us} + {p_vc[P_W-1], p_vc};

  always_ff @(posedge clk) begin
    if (adv) begin
      r_u <= $signed(sum_u[P_W:affc_pkg::FRAC_W]);
      r_v <= $signed(sum_v[P_W:affc_pkg::FRAC_W]);
    end
  end

  // Stage 3: inverse scale products.
  assign m_u_next = r_u * $signed({1'b0, cfg.inv_scale_u});
  assign m_v_next = r_v * $signed({1'b0, cfg.inv_scale_v});

  always_ff @(posedge clk) begin
    if (adv) begin
      m_u <= m_u_next;
      m_v <= m_v_next;
    end
  end

  // Stage 4: floor, re-centre and subtract the translation.
  assign t_u_next = {m_u[SC_W-1], m_u[SC_W-1:affc_pkg::FRAC_W]}
                  + T_W'(affc_pkg::HALF_Q16)
                  - {{(T_W-affc_pkg::TRANS_W){cfg.translate_u[affc_pkg::TRANS_W-1]}},
                     cfg.translate_u};
  assign t_v_next = {m_v[SC_W-1], m_v[SC_W-1:affc_pkg::FRAC_W]}
                  + T_W'(affc_pkg::HALF_Q16)
                  - {{(T_W-affc_pkg::TRANS_W){cfg.translate_v[affc_pkg::TRANS_W-1]}},
                     cfg.translate_v};

  always_ff @(posedge clk) begin
    if (adv) begin
      t_u <= t_u_next;
      t_v <= t_v_next;
    end
  end

  // Wrap one coordinate. Mirror only needs the low bits of |t|, which
  // follow from the low bits of t and its sign.
  function automatic logic [S_W-1:0] wrap(input logic [affc_pkg::MODE_W-1:0] mode,
                                          input logic signed [T_W-1:0] t);
    logic             neg;
    logic             over;
    logic [S_W-1:0]   lo;
    logic [S_W-1:0]   mag;
    logic [S_W-1:0]   res;
    neg  = t[T_W-1];
    over = !neg && (t[T_W-2:0] > (T_W-1)'(affc_pkg::ONE_Q16));
    lo   = t[S_W-1:0];
    mag  = neg ? (~lo + S_W'(1)) : lo;
    unique case (affc_pkg::ext_mode_t'(mode))
      affc_pkg::EXT_CLAMP: begin
        if (neg) begin
          res = '0;
        end else if (over) begin
          res = S_W'(affc_pkg::ONE_Q16);
        end else begin
          res = lo;
        end
      end
      affc_pkg::EXT_TILE: begin
        res = {1'b0, lo[S_W-2:0]};
      end
      default: begin
        // Reflect the upper half of the period back into range.
        res = (mag > S_W'(affc_pkg::ONE_Q16)) ? (~mag + S_W'(1)) : mag;
      end
    endcase
    return res;
  endfunction

  // Stage 5: output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      src_u <= wrap(cfg.extend_mode, t_u);
      src_v <= wrap(cfg.extend_mode, t_v);
    end
  end

endmodule

`default_nettype wire

[rtl/affine_texture_coord_wrap.sv]
// ----------------------------------------------------------------------------
// affine_texture_coord_wrap: affine texture address with clamp/mirror/tile
// Maps an output pixel position to a wrapped source texture coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one pixel item (pix_x, pix_y).
//   Output channel out_valid/out_ready returns one item (src_u, src_v) per
//   input item, in order, in Q1.16 with 65536 meaning 1.0.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high and unknown indexes are ignored. The user must
//   change registers only while no item is in flight; not enforced by the block.
// Timing:
//   One item per clock sustained while out_ready is high. From acceptance to
//   out_valid an item passes two stages of coordinate normalization, the
//   queue, and five stages of rotate, scale, translate and wrap.
// Reset:
//   rst is synchronous; it empties the pipeline and queue and loads the
//   register defaults (identity transform, clamp mode).
// Stalls:
//   When out_ready is low the transform stages hold, the queue fills, and
//   in_ready drops only once the queue and the front stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_texture_coord_wrap #(
  parameter int OUT_WIDTH  = affc_pkg::DEF_OUT_WIDTH,
  parameter int OUT_HEIGHT = affc_pkg::DEF_OUT_HEIGHT,
  parameter int FIFO_DEPTH = affc_pkg::DEF_FIFO_DEPTH
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [affc_pkg::PIX_W-1:0]            pix_x,
  input  wire  [affc_pkg::PIX_W-1:0]            pix_y,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [affc_pkg::SRC_W-1:0]            src_u,
  output logic [affc_pkg::SRC_W-1:0]            src_v,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [affc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [affc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Coordinate width covers the larger of the two normalized axes.
  localparam int QX_W  = $clog2((affc_pkg::PIX_MAX * affc_pkg::ONE_Q16) / OUT_WIDTH + 1);
  localparam int QY_W  = $clog2((affc_pkg::PIX_MAX * affc_pkg::ONE_Q16) / OUT_HEIGHT + 1);
  localparam int QM_W  = (QX_W > QY_W) ? QX_W : QY_W;
  localparam int C_W   = (QM_W + 1 > affc_pkg::SRC_W) ? QM_W + 1 : affc_pkg::SRC_W;

  affc_pkg::cfg_t cfg;

  logic                  fq_valid;
  logic                  fq_ready;
  logic signed [C_W-1:0] fq_u;
  logic signed [C_W-1:0] fq_v;
  logic                  bq_valid;
  logic                  bq_ready;
  logic [2*C_W-1:0]      bq_data;

  // Register file; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.translate_u <= '0;
      cfg.translate_v <= '0;
      cfg.inv_scale_u <= affc_pkg::SCALE_W'(affc_pkg::ONE_Q16);
      cfg.inv_scale_v <= affc_pkg::SCALE_W'(affc_pkg::ONE_Q16);
      cfg.rot_cos     <= affc_pkg::ROT_W'(affc_pkg::ONE_Q16);
      cfg.rot_sin     <= '0;
      cfg.extend_mode <= affc_pkg::EXT_CLAMP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        affc_pkg::REG_TRANSLATE_U: cfg.translate_u <= cfg_data[affc_pkg::TRANS_W-1:0];
        affc_pkg::REG_TRANSLATE_V: cfg.translate_v <= cfg_data[affc_pkg::TRANS_W-1:0];
        affc_pkg::REG_INV_SCALE_U: cfg.inv_scale_u <= cfg_data[affc_pkg::SCALE_W-1:0];
        affc_pkg::REG_INV_SCALE_V: cfg.inv_scale_v <= cfg_data[affc_pkg::SCALE_W-1:0];
        affc_pkg::REG_ROT_COS:     cfg.rot_cos     <= cfg_data[affc_pkg::ROT_W-1:0];
        affc_pkg::REG_ROT_SIN:     cfg.rot_sin     <= cfg_data[affc_pkg::ROT_W-1:0];
        affc_pkg::REG_EXTEND_MODE: cfg.extend_mode <= cfg_data[affc_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept pixel items and normalize them.
  affc_front #(
    .OUT_WIDTH (OUT_WIDTH),
    .OUT_HEIGHT(OUT_HEIGHT),
    .C_W       (C_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pix_x   (pix_x),
    .pix_y   (pix_y),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_u     (fq_u),
    .q_v     (fq_v)
  );

  // Queue decoupling the two halves.
  affc_fifo #(
    .WIDTH(2 * C_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_data ({fq_u, fq_v}),
    .rd_valid(bq_valid),
    .rd_ready(bq_ready),
    .rd_data (bq_data)
  );

  // Back: transform and wrap.
  affc_back #(
    .C_W(C_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_u      ($signed(bq_data[2*C_W-1:C_W])),
    .q_v      ($signed(bq_data[C_W-1:0])),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .src_u    (src_u),
    .src_v    (src_v)
  );

endmodule

`default_nettype wire
